// ===== design/kmh_pkg.sv =====
// Shared constants, types and codes for the k-way merge min-heap.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package kmh_pkg;

	// Heap capacity, one slot per merged stream
	localparam int MAX_STREAMS = 16;
	localparam int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
	localparam int CHILD_W     = IDX_W + 2;

	// Field widths
	localparam int KEY_W  = 32;
	localparam int SRC_W  = 4;
	localparam int ENT_W  = 5;
	localparam int STAT_W = 2;
	localparam int OP_W   = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
	localparam logic [OP_W-1:0] OP_POP     = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [SRC_W-1:0]        src_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [CHILD_W-1:0]      child_t;
	typedef logic [ENT_W-1:0]        entries_t;

	// One heap slot
	typedef struct packed {
		key_t key;
		src_t src;
	} entry_t;

	// Compare unit verdict: which candidate beats the base
	typedef struct packed {
		logic pick_a;
		logic pick_b;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== design/kway_merge_min_heap.sv =====
// K-way merge min-heap: sequencer around the heap RAM and the compare unit.
// Each operation is issued first; then an insert into a non-empty heap climbs toward the root,
// and a replace or pop descends from it, one level per step, before the result is posted.
// Operations are taken one at a time: input stalls until the result is posted.
// Reset clears the occupancy, the sequencer and the output register.
`default_nettype none

module kway_merge_min_heap (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [kmh_pkg::OP_W-1:0]          opcode,
	input  wire logic signed [kmh_pkg::KEY_W-1:0]  key_value,
	input  wire logic [kmh_pkg::SRC_W-1:0]         source_index,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [kmh_pkg::KEY_W-1:0]       min_value,
	output logic [kmh_pkg::SRC_W-1:0]              min_source,
	output logic [kmh_pkg::ENT_W-1:0]              entries_left,
	output logic [kmh_pkg::STAT_W-1:0]             status
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_ISSUE     = 3'd1;
	localparam logic [2:0] S_UP        = 3'd2;
	localparam logic [2:0] S_DOWN_HEAD = 3'd3;
	localparam logic [2:0] S_DOWN      = 3'd4;
	localparam logic [2:0] S_PLACE     = 3'd5;
	localparam logic [2:0] S_POST      = 3'd6;

	logic [2:0]                     state_q;
	logic [kmh_pkg::OP_W-1:0]       op_q;
	kmh_pkg::key_t                  key_q;
	kmh_pkg::src_t                  src_q;
	kmh_pkg::entry_t                ent_q;
	kmh_pkg::idx_t                  node_q;
	kmh_pkg::cnt_t                  count_q;
	kmh_pkg::entry_t                rep_q;
	logic [kmh_pkg::STAT_W-1:0]     stat_q;
	logic                           out_valid_q;
	kmh_pkg::entry_t                out_ent_q;
	kmh_pkg::entries_t              out_cnt_q;
	logic [kmh_pkg::STAT_W-1:0]     out_stat_q;

	logic                           we;
	kmh_pkg::idx_t                  wr_addr;
	kmh_pkg::entry_t                wr_data;
	kmh_pkg::idx_t                  rd_addr_a;
	kmh_pkg::idx_t                  rd_addr_b;
	kmh_pkg::entry_t                rd_data_a;
	kmh_pkg::entry_t                rd_data_b;

	kmh_pkg::key_t                  cmp_base;
	logic                           cmp_a_ok;
	logic                           cmp_b_ok;
	kmh_pkg::cmp_res_t              cmp_res;

	kmh_pkg::child_t                left_c;
	kmh_pkg::child_t                right_c;
	kmh_pkg::child_t                count_c;
	kmh_pkg::idx_t                  parent_idx;
	kmh_pkg::idx_t                  grand_idx;
	kmh_pkg::idx_t                  ins_parent;
	kmh_pkg::idx_t                  next_node;
	kmh_pkg::child_t                next_left;
	logic                           heap_full;
	logic                           heap_empty;

	kmh_heap_ram u_ram (
		.clk       (clk),
		.we        (we),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	kmh_cmp_unit u_cmp (
		.base_key (cmp_base),
		.a_key    ((state_q == S_UP) ? ent_q.key : rd_data_a.key),
		.a_ok     (cmp_a_ok),
		.b_key    (rd_data_b.key),
		.b_ok     (cmp_b_ok),
		.res      (cmp_res)
	);

	// Index arithmetic around the current node
	always_comb begin
		left_c     = kmh_pkg::child_t'({node_q, 1'b1});
		right_c    = left_c + kmh_pkg::child_t'(1);
		count_c    = kmh_pkg::child_t'(count_q);
		parent_idx = (node_q - kmh_pkg::idx_t'(1)) >> 1;
		grand_idx  = (parent_idx - kmh_pkg::idx_t'(1)) >> 1;
		ins_parent = (kmh_pkg::idx_t'(count_q) - kmh_pkg::idx_t'(1)) >> 1;
		next_node  = cmp_res.pick_a ? kmh_pkg::idx_t'(left_c) : kmh_pkg::idx_t'(right_c);
		next_left  = kmh_pkg::child_t'({next_node, 1'b1});
		heap_full  = count_q >= kmh_pkg::cnt_t'(kmh_pkg::MAX_STREAMS);
		heap_empty = count_q == '0;
	end

	// Drive RAM ports and compare operands for the current step
	always_comb begin
		we        = 1'b0;
		wr_addr   = node_q;
		wr_data   = ent_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		cmp_base  = ent_q.key;
		cmp_a_ok  = 1'b0;
		cmp_b_ok  = 1'b0;
		case (state_q)
			S_ISSUE: begin
				if (op_q == kmh_pkg::OP_INSERT) begin
					if (!heap_full && heap_empty) begin
						we      = 1'b1;
						wr_addr = '0;
						wr_data = '{key: key_q, src: src_q};
					end
					rd_addr_a = ins_parent;
				end else begin
					rd_addr_b = kmh_pkg::idx_t'(count_q - kmh_pkg::cnt_t'(1));
				end
			end
			S_DOWN_HEAD: begin
				rd_addr_a = kmh_pkg::idx_t'(left_c);
				rd_addr_b = kmh_pkg::idx_t'(right_c);
			end
			S_UP: begin
				// Parent is the base; the moving entry wins only on strictly less
				cmp_base  = rd_data_a.key;
				cmp_a_ok  = 1'b1;
				we        = 1'b1;
				wr_data   = cmp_res.pick_a ? rd_data_a : ent_q;
				rd_addr_a = grand_idx;
			end
			S_DOWN: begin
				cmp_a_ok  = left_c < count_c;
				cmp_b_ok  = right_c < count_c;
				we        = 1'b1;
				wr_data   = cmp_res.pick_a ? rd_data_a : (cmp_res.pick_b ? rd_data_b : ent_q);
				rd_addr_a = kmh_pkg::idx_t'(next_left);
				rd_addr_b = kmh_pkg::idx_t'(next_left + kmh_pkg::child_t'(1));
			end
			S_PLACE: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, heap occupancy and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			key_q       <= '0;
			src_q       <= '0;
			ent_q       <= '0;
			node_q      <= '0;
			count_q     <= '0;
			rep_q       <= '0;
			stat_q      <= kmh_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_ent_q   <= '0;
			out_cnt_q   <= '0;
			out_stat_q  <= kmh_pkg::ST_OK;
		end else begin
			// Drop the result once its transfer completes; posting owns its own cycle
			if (out_valid_q && !out_stall && state_q != S_POST) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						key_q   <= key_value;
						src_q   <= source_index;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					rep_q  <= '0;
					stat_q <= kmh_pkg::ST_OK;
					case (op_q)
						kmh_pkg::OP_INSERT: begin
							if (heap_full) begin
								stat_q  <= kmh_pkg::ST_FULL;
								state_q <= S_POST;
							end else begin
								ent_q   <= '{key: key_q, src: src_q};
								node_q  <= kmh_pkg::idx_t'(count_q);
								count_q <= count_q + kmh_pkg::cnt_t'(1);
								state_q <= heap_empty ? S_POST : S_UP;
							end
						end
						kmh_pkg::OP_REPLACE, kmh_pkg::OP_POP: begin
							if (heap_empty) begin
								stat_q  <= kmh_pkg::ST_EMPTY;
								state_q <= S_POST;
							end else begin
								if (op_q == kmh_pkg::OP_POP) begin
									count_q <= count_q - kmh_pkg::cnt_t'(1);
								end
								node_q  <= '0;
								state_q <= S_DOWN_HEAD;
							end
						end
						default: begin
							state_q <= S_POST;
						end
					endcase
				end
				S_DOWN_HEAD: begin
					// Report the old root and start from the new one
					rep_q <= rd_data_a;
					if (op_q == kmh_pkg::OP_REPLACE) begin
						ent_q <= '{key: key_q, src: rd_data_a.src};
					end else begin
						ent_q <= rd_data_b;
					end
					state_q <= S_DOWN;
				end
				S_UP: begin
					if (cmp_res.pick_a) begin
						node_q <= parent_idx;
						if (parent_idx == '0) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_POST;
					end
				end
				S_DOWN: begin
					if (cmp_res.pick_a || cmp_res.pick_b) begin
						node_q <= next_node;
					end else begin
						state_q <= S_POST;
					end
				end
				S_PLACE: begin
					state_q <= S_POST;
				end
				S_POST: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_ent_q   <= rep_q;
						out_cnt_q   <= kmh_pkg::entries_t'(count_q);
						out_stat_q  <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = out_valid_q;
	assign min_value    = out_ent_q.key;
	assign min_source   = out_ent_q.src;
	assign entries_left = out_cnt_q;
	assign status       = out_stat_q;

endmodule

`default_nettype wire

// ===== design/kmh_heap_ram.sv =====
// Heap storage: one write port, two read ports with registered read data.
// Depends on kmh_pkg for the entry type and the depth.
`default_nettype none

module kmh_heap_ram (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire kmh_pkg::idx_t        wr_addr,
	input  wire kmh_pkg::entry_t      wr_data,
	input  wire kmh_pkg::idx_t        rd_addr_a,
	input  wire kmh_pkg::idx_t        rd_addr_b,
	output kmh_pkg::entry_t           rd_data_a,
	output kmh_pkg::entry_t           rd_data_b
);

	kmh_pkg::entry_t mem [kmh_pkg::MAX_STREAMS];

	// Write one slot
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register both reads
	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

`default_nettype wire

// ===== design/kmh_cmp_unit.sv =====
// Shared key compare unit: picks the strict minimum of a base key and up to
// two candidates, keeping the base on a tie and candidate a over b on a tie.
// Depends on kmh_pkg for key and verdict types.
`default_nettype none

module kmh_cmp_unit (
	input  wire kmh_pkg::key_t base_key,
	input  wire kmh_pkg::key_t a_key,
	input  wire logic          a_ok,
	input  wire kmh_pkg::key_t b_key,
	input  wire logic          b_ok,
	output kmh_pkg::cmp_res_t  res
);

	logic          a_lt;
	logic          b_lt;
	kmh_pkg::key_t best_key;

	// Candidate a against the base, then b against the winner
	always_comb begin
		a_lt       = a_ok && ($signed(a_key) < $signed(base_key));
		best_key   = a_lt ? a_key : base_key;
		b_lt       = b_ok && ($signed(b_key) < $signed(best_key));
		res.pick_b = b_lt;
		res.pick_a = a_lt && !b_lt;
	end

endmodule

`default_nettype wire

// ===== tb/kmh_heap_checker.sv =====
// Checker for the k-way merge min-heap: mirrors the heap from accepted transfers
// and compares each result (root, entries left, status) against its prediction. Depends on kmh_pkg.
module kmh_heap_checker
	import kmh_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire logic [OP_W-1:0]        opcode,
	input  wire logic signed [KEY_W-1:0] key_value,
	input  wire logic [SRC_W-1:0]       source_index,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic signed [KEY_W-1:0] min_value,
	input  wire logic [SRC_W-1:0]       min_source,
	input  wire logic [ENT_W-1:0]       entries_left,
	input  wire logic [STAT_W-1:0]      status,
	output int                          errors,
	output int                          pending,
	output int                          results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		key_t              value;
		src_t              source;
		entries_t          left;
		logic [STAT_W-1:0] stat;
	} root_report_t;

	// Mirror of the heap contents
	key_t heap_key [MAX_STREAMS];
	src_t heap_src [MAX_STREAMS];
	int   occupancy;

	root_report_t expected_reports[$];

	initial begin
		errors = 0;
		results_checked = 0;
		occupancy = 0;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] heap mismatch: %s", $realtime, msg);
	endtask

	function automatic void swap_slots(input int a, input int b);
		key_t k;
		src_t s;
		k = heap_key[a];
		s = heap_src[a];
		heap_key[a] = heap_key[b];
		heap_src[a] = heap_src[b];
		heap_key[b] = k;
		heap_src[b] = s;
	endfunction

	// Apply one operation to the mirror and return the root report it yields
	function automatic root_report_t apply_heap_op(input logic [OP_W-1:0] op,
			input key_t key, input src_t src);
		root_report_t r;
		int node;
		int parent;
		int best;
		int child;
		bit done;
		r = '0;
		case (op)
			OP_INSERT: begin
				if (occupancy >= MAX_STREAMS) begin
					r.stat = ST_FULL;
				end else begin
					heap_key[occupancy] = key;
					heap_src[occupancy] = src;
					// sift up, swap only on strictly less
					node = occupancy;
					done = 1'b0;
					while (node > 0 && !done) begin
						parent = (node - 1) / 2;
						if (heap_key[node] < heap_key[parent]) begin
							swap_slots(node, parent);
							node = parent;
						end else begin
							done = 1'b1;
						end
					end
					occupancy++;
				end
			end
			OP_REPLACE, OP_POP: begin
				if (occupancy == 0) begin
					r.stat = ST_EMPTY;
				end else begin
					r.value = heap_key[0];
					r.source = heap_src[0];
					if (op == OP_REPLACE) begin
						heap_key[0] = key;
					end else begin
						occupancy--;
						heap_key[0] = heap_key[occupancy];
						heap_src[0] = heap_src[occupancy];
					end
					// sift down: parent wins ties, left child wins a child tie
					node = 0;
					done = 1'b0;
					while (!done) begin
						best = node;
						child = 2 * node + 1;
						if (child < occupancy && heap_key[child] < heap_key[best])
							best = child;
						child = 2 * node + 2;
						if (child < occupancy && heap_key[child] < heap_key[best])
							best = child;
						if (best == node) begin
							done = 1'b1;
						end else begin
							swap_slots(node, best);
							node = best;
						end
					end
				end
			end
			default: ;
		endcase
		r.left = entries_t'(occupancy);
		return r;
	endfunction

	// Compare results first: a result at this edge belongs to an earlier transfer
	always @(posedge clk or negedge arst_n) begin
		root_report_t want;
		if (!arst_n) begin
			occupancy = 0;
			expected_reports.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d source %0d",
						min_value, min_source));
				end else begin
					want = expected_reports.pop_front();
					if (min_value !== want.value)
						report_mismatch($sformatf("min_value got %0d want %0d",
							min_value, want.value));
					if (min_source !== want.source)
						report_mismatch($sformatf("min_source got %0d want %0d",
							min_source, want.source));
					if (entries_left !== want.left)
						report_mismatch($sformatf("entries_left got %0d want %0d",
							entries_left, want.left));
					if (status !== want.stat)
						report_mismatch($sformatf("status got %0d want %0d",
							status, want.stat));
				end
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(apply_heap_op(opcode, key_value, source_index));
			pending <= expected_reports.size();
		end
	end

endmodule

// ===== tb/tb_kway_merge_min_heap.sv =====
// Testbench top for the k-way merge min-heap: clock, reset, operation stimulus
// and receiver stalls. Depends on kmh_pkg, kway_merge_min_heap and kmh_heap_checker.
module tb_kway_merge_min_heap;
	timeunit 1ns;
	timeprecision 1ps;
	import kmh_pkg::*;

	localparam int TOTAL_ITEMS = 875;
	localparam int LONG_HOLD   = 150;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   opcode;
	key_t              key_value;
	src_t              source_index;
	logic              out_valid;
	logic              out_stall;
	key_t              min_value;
	src_t              min_source;
	entries_t          entries_left;
	logic [STAT_W-1:0] status;

	int errors;
	int pending;
	int results_checked;

	// Stimulus bookkeeping: occupancy as seen by the sender, and op counts
	int  fill_level;
	int  items_sent;
	int  n_insert, n_replace, n_pop, n_full, n_empty;
	bit  calm_tx;
	bit  hold_req;

	kway_merge_min_heap u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.key_value    (key_value),
		.source_index (source_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.min_value    (min_value),
		.min_source   (min_source),
		.entries_left (entries_left),
		.status       (status)
	);

	kmh_heap_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.key_value       (key_value),
		.source_index    (source_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.min_value       (min_value),
		.min_source      (min_source),
		.entries_left    (entries_left),
		.status          (status),
		.errors          (errors),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Give up after a generous fixed time
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random short and long stalls, calm stretches, one long hold on request
	initial begin
		int stall_left;
		int roll;
		bit calm_rx;
		stall_left = 0;
		calm_rx = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0)
				calm_rx = !calm_rx;
			if (hold_req && stall_left == 0) begin
				stall_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (stall_left == 0 && !calm_rx) begin
				roll = $urandom_range(0, 99);
				if (roll < 20)
					stall_left = $urandom_range(1, 3);
				else if (roll < 23)
					stall_left = $urandom_range(8, 30);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one operation and hold it until the transfer
	task automatic send_op(input logic [OP_W-1:0] op, input key_t key, input src_t src);
		in_valid <= 1'b1;
		opcode <= op;
		key_value <= key;
		source_index <= src;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		case (op)
			OP_INSERT: begin
				n_insert++;
				if (fill_level >= MAX_STREAMS)
					n_full++;
				else
					fill_level++;
			end
			OP_REPLACE, OP_POP: begin
				if (op == OP_REPLACE)
					n_replace++;
				else
					n_pop++;
				if (fill_level == 0)
					n_empty++;
				else if (op == OP_POP)
					fill_level--;
			end
			default: ;
		endcase
	endtask

	// Send, then leave a random gap: mostly none, a few long
	task automatic issue(input logic [OP_W-1:0] op, input key_t key, input src_t src);
		int roll;
		int gap;
		send_op(op, key, src);
		gap = 0;
		if (!calm_tx) begin
			roll = $urandom_range(0, 99);
			if (roll < 25)
				gap = $urandom_range(1, 3);
			else if (roll < 30)
				gap = $urandom_range(8, 30);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pause the sender until every expected result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Keys clustered near a running base for ties, with some full-range and extremes
	function automatic key_t near_key(input int base);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return key_t'(base + $urandom_range(0, 3));
		else if (roll < 90)
			return key_t'($urandom);
		else if (roll < 95)
			return key_t'(32'h8000_0000);
		else
			return key_t'(32'h7fff_ffff);
	endfunction

	initial begin
		int base;
		int fanin;
		bit first_phase;
		key_t directed_keys [16];
		directed_keys = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 5, 5, 5, 3,
			3, 7, 1, -7, 5, 32'sh4000_0000, 32'sh8000_0001, 2};
		fill_level = 0;
		items_sent = 0;
		n_insert = 0;
		n_replace = 0;
		n_pop = 0;
		n_full = 0;
		n_empty = 0;
		calm_tx = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_INSERT;
		key_value <= '0;
		source_index <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty heap, fill with extremes and ties, full heap, replace, pop
		issue(OP_POP, 32'sd9, 4'd9);
		issue(OP_REPLACE, 32'sd11, 4'd3);
		for (int i = 0; i < MAX_STREAMS; i++)
			issue(OP_INSERT, directed_keys[i], src_t'(MAX_STREAMS - 1 - i));
		issue(OP_INSERT, 32'sd0, 4'd15);
		issue(OP_REPLACE, 32'sh7fff_ffff, 4'd0);
		issue(OP_REPLACE, 32'sh8000_0000, 4'd0);
		repeat (4) issue(OP_POP, 32'sd0, 4'd0);
		wait_drained();

		// Random merge phases: fill k streams, advance by replaces, noise, drain by pops
		first_phase = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			calm_tx = ($urandom_range(0, 3) == 0);
			if (first_phase) begin
				// receiver holds off while the sender offers back to back
				calm_tx = 1'b1;
				hold_req = 1'b1;
				first_phase = 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				wait_drained();
			end
			fanin = ($urandom_range(0, 3) == 0) ? MAX_STREAMS
				: $urandom_range(2, MAX_STREAMS);
			base = ($urandom_range(0, 5) == 0) ? int'(32'h8000_0000) + $urandom_range(0, 7)
				: int'($urandom_range(0, 200)) - 100;
			while (fill_level < fanin)
				issue(OP_INSERT, near_key(base), src_t'($urandom_range(0, 15)));
			if (fill_level == MAX_STREAMS && $urandom_range(0, 1) == 0)
				issue(OP_INSERT, near_key(base), src_t'($urandom_range(0, 15)));
			repeat ($urandom_range(5, 40)) begin
				base += $urandom_range(0, 3);
				issue(OP_REPLACE, near_key(base), src_t'($urandom_range(0, 15)));
			end
			// noise, including the unused opcode
			repeat ($urandom_range(0, 6))
				issue(OP_W'($urandom_range(0, 3)), key_t'($urandom),
					src_t'($urandom_range(0, 15)));
			while (fill_level > 0)
				issue(OP_POP, key_t'($urandom), src_t'($urandom_range(0, 15)));
			if ($urandom_range(0, 2) == 0)
				issue(($urandom_range(0, 1) == 0) ? OP_POP : OP_REPLACE, key_t'($urandom),
					src_t'($urandom_range(0, 15)));
		end

		// Drain, then keep watching for any stray result before the summary
		wait_drained();
		repeat (30) @(posedge clk);
		$display("Sent %0d operations: %0d inserts, %0d replaces, %0d pops.",
			items_sent, n_insert, n_replace, n_pop);
		$display("%0d inserts hit a full heap, %0d replace/pop hit an empty one;",
			n_full, n_empty);
		$display("%0d results checked.", results_checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/kmh_pkg.sv
design/kmh_heap_ram.sv
design/kmh_cmp_unit.sv
design/kway_merge_min_heap.sv
tb/kmh_heap_checker.sv
tb/tb_kway_merge_min_heap.sv
